>>> rtl/llc_pkg.sv
// Shared types and constants for the linked list with cursor block.
// Depends on nothing; used by llc_node_mem and linked_list_with_cursor_top.
package llc_pkg;

	// Width of one stored element value.
	localparam int VALUE_W = 32;

	// Width of the command field.
	localparam int CMD_W = 4;

	// Command codes. Codes above CMD_ADVANCE behave as a query.
	typedef enum logic [CMD_W-1:0] {
		CMD_QUERY     = 4'd0,
		CMD_CLEAR     = 4'd1,
		CMD_INS_HEAD  = 4'd2,
		CMD_CUR_HEAD  = 4'd3,
		CMD_DEL_HEAD  = 4'd4,
		CMD_DEL_AFTER = 4'd5,
		CMD_INS_AFTER = 4'd6,
		CMD_SET_VALUE = 4'd7,
		CMD_ADVANCE   = 4'd8
	} cmd_t;

	// Command sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_COMMIT
	} state_t;

endpackage

>>> rtl/llc_node_mem.sv
// Node pool storage: element values and next links, one synchronous read
// and one write port each. Depends on llc_pkg for the value width.
module llc_node_mem #(
	parameter int DEPTH = 64,
	parameter int IW    = 6,
	parameter int PW    = 7
) (
	input  logic                             clk,
	input  logic [IW-1:0]                    link_raddr,
	output logic [PW-1:0]                    link_rdata,
	input  logic                             link_we,
	input  logic [IW-1:0]                    link_waddr,
	input  logic [PW-1:0]                    link_wdata,
	input  logic [IW-1:0]                    value_raddr,
	output logic signed [llc_pkg::VALUE_W-1:0] value_rdata,
	input  logic                             value_we,
	input  logic [IW-1:0]                    value_waddr,
	input  logic signed [llc_pkg::VALUE_W-1:0] value_wdata
);

	logic [PW-1:0]                     link_mem [DEPTH];
	logic signed [llc_pkg::VALUE_W-1:0] value_mem [DEPTH];

	// Link store. A read at the address being written returns the old entry.
	always_ff @(posedge clk) begin
		link_rdata <= link_mem[link_raddr];
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
	end

	// Value store, same read-before-write behavior.
	always_ff @(posedge clk) begin
		value_rdata <= value_mem[value_raddr];
		if (value_we) begin
			value_mem[value_waddr] <= value_wdata;
		end
	end

endmodule

>>> rtl/linked_list_with_cursor_top.sv
// Singly linked list with a cursor, kept in a node pool memory.
// Depends on llc_pkg and llc_node_mem.
//
// Usage:
//   A command beat (cmd, value_in) is taken on a rising edge where start is
//   high and busy is low. Each command yields exactly one result beat, shown
//   for one cycle with done high: head_value/head_present, cursor_value/
//   cursor_active, element_count and pool_error, all describing the list
//   after the command. The receiver cannot stall; results must be taken.
//   After the accepting edge the sequencer passes through fetch and commit;
//   done rises as busy drops, and no new command is taken until then.
//   The steps follow the node memory port: the first link is read on the
//   accepting edge, fetch reads the second link or a value while the first
//   write-back happens, and commit sets the pointers and the last link.
//   Head and cursor values are cached in registers, so results need no
//   further memory read.
//   Reset (arst_n low) empties the list, drops the cursor and returns the
//   whole pool; node memory is not cleared and needs no sweep, since an
//   entry is only used after it has been written.
module linked_list_with_cursor_top #(
	parameter int POOL_NODES = 64,
	localparam int PW = $clog2(POOL_NODES + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [llc_pkg::CMD_W-1:0]         cmd,
	input  logic signed [llc_pkg::VALUE_W-1:0] value_in,
	output logic                              done,
	output logic signed [llc_pkg::VALUE_W-1:0] head_value,
	output logic                              head_present,
	output logic signed [llc_pkg::VALUE_W-1:0] cursor_value,
	output logic                              cursor_active,
	output logic [PW-1:0]                     element_count,
	output logic                              pool_error
);

	localparam int IW = $clog2(POOL_NODES);
	localparam logic [PW-1:0] NONE = PW'(POOL_NODES);

	// A pointer names a node only when it lies below the pool size.
	function automatic logic is_node(input logic [PW-1:0] p);
		return p < NONE;
	endfunction

	// Memory index of a pointer; the none marker maps to entry zero.
	function automatic logic [IW-1:0] idx(input logic [PW-1:0] p);
		return (p < NONE) ? p[IW-1:0] : '0;
	endfunction

	llc_pkg::state_t state_q, state_d;
	llc_pkg::cmd_t   cmd_q;
	logic signed [llc_pkg::VALUE_W-1:0] val_q;
	logic [PW-1:0] link1_s2;

	logic [PW-1:0] head_q, cur_q, free_q, fresh_q, count_q;
	logic [PW-1:0] head_d, cur_d, free_d, fresh_d, count_d;
	logic signed [llc_pkg::VALUE_W-1:0] head_val_q, cur_val_q, head_val_d, cur_val_d;
	logic err_q, err_d, done_q;

	logic                              alloc_ok;
	logic [PW-1:0]                     alloc_node;
	logic                              cur_ok;

	logic [IW-1:0]                     link_raddr, link_waddr, value_raddr, value_waddr;
	logic [PW-1:0]                     link_rdata, link_wdata;
	logic                              link_we, value_we;
	logic signed [llc_pkg::VALUE_W-1:0] value_rdata, value_wdata;

	llc_node_mem #(
		.DEPTH(POOL_NODES),
		.IW   (IW),
		.PW   (PW)
	) u_mem (
		.clk        (clk),
		.link_raddr (link_raddr),
		.link_rdata (link_rdata),
		.link_we    (link_we),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.value_raddr(value_raddr),
		.value_rdata(value_rdata),
		.value_we   (value_we),
		.value_waddr(value_waddr),
		.value_wdata(value_wdata)
	);

	// Node allocation: freed nodes first, then never-used ones.
	assign alloc_ok   = is_node(free_q) || (fresh_q < NONE);
	assign alloc_node = is_node(free_q) ? free_q : fresh_q;
	assign cur_ok     = is_node(cur_q);

	// Next state of the command sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			llc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = llc_pkg::ST_FETCH;
				end
			end
			llc_pkg::ST_FETCH:  state_d = llc_pkg::ST_COMMIT;
			llc_pkg::ST_COMMIT: state_d = llc_pkg::ST_IDLE;
			default:            state_d = llc_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		unique case (state_q)
			llc_pkg::ST_IDLE: busy = 1'b0;
			default:          busy = 1'b1;
		endcase
	end

	// Memory accesses: first link read on accept, second read and the
	// first write-back in the fetch cycle, last link write at commit.
	always_comb begin
		link_raddr  = idx(cur_q);
		link_we     = 1'b0;
		link_waddr  = idx(alloc_node);
		link_wdata  = free_q;
		value_raddr = idx(link_rdata);
		value_we    = 1'b0;
		value_waddr = idx(alloc_node);
		value_wdata = val_q;
		case (state_q)
			llc_pkg::ST_IDLE: begin
				if (cmd == llc_pkg::CMD_INS_HEAD) begin
					link_raddr = idx(free_q);
				end else if (cmd == llc_pkg::CMD_DEL_HEAD) begin
					link_raddr = idx(head_q);
				end
			end
			llc_pkg::ST_FETCH: begin
				case (cmd_q)
					llc_pkg::CMD_INS_HEAD: begin
						if (alloc_ok) begin
							link_we    = 1'b1;
							link_wdata = head_q;
							value_we   = 1'b1;
						end
					end
					llc_pkg::CMD_DEL_HEAD: begin
						if (is_node(head_q)) begin
							link_we    = 1'b1;
							link_waddr = idx(head_q);
						end
					end
					llc_pkg::CMD_DEL_AFTER: begin
						link_raddr = idx(link_rdata);
						if (cur_ok && is_node(link_rdata)) begin
							link_we    = 1'b1;
							link_waddr = idx(link_rdata);
						end
					end
					llc_pkg::CMD_INS_AFTER: begin
						link_raddr = idx(free_q);
						if (cur_ok && alloc_ok) begin
							link_we    = 1'b1;
							link_wdata = link_rdata;
							value_we   = 1'b1;
						end
					end
					llc_pkg::CMD_SET_VALUE: begin
						if (cur_ok) begin
							value_we    = 1'b1;
							value_waddr = idx(cur_q);
						end
					end
					default: begin
					end
				endcase
			end
			llc_pkg::ST_COMMIT: begin
				if (cmd_q == llc_pkg::CMD_DEL_AFTER && cur_ok && is_node(link1_s2)) begin
					link_we    = 1'b1;
					link_waddr = idx(cur_q);
					link_wdata = link_rdata;
				end else if (cmd_q == llc_pkg::CMD_INS_AFTER && cur_ok && alloc_ok) begin
					link_we    = 1'b1;
					link_waddr = idx(cur_q);
					link_wdata = alloc_node;
				end
			end
			default: begin
			end
		endcase
	end

	// List state update at commit. The first link read is held in link1_s2,
	// the second link read and the value read are on the memory outputs.
	always_comb begin
		head_d     = head_q;
		cur_d      = cur_q;
		free_d     = free_q;
		fresh_d    = fresh_q;
		count_d    = count_q;
		head_val_d = head_val_q;
		cur_val_d  = cur_val_q;
		err_d      = err_q;
		if (state_q == llc_pkg::ST_COMMIT) begin
			err_d = 1'b0;
			case (cmd_q)
				llc_pkg::CMD_CLEAR: begin
					head_d  = NONE;
					cur_d   = NONE;
					free_d  = NONE;
					fresh_d = '0;
					count_d = '0;
				end
				llc_pkg::CMD_INS_HEAD: begin
					if (alloc_ok) begin
						if (is_node(free_q)) begin
							free_d = is_node(link1_s2) ? link1_s2 : NONE;
						end else begin
							fresh_d = fresh_q + PW'(1);
						end
						head_d     = alloc_node;
						head_val_d = val_q;
						count_d    = count_q + PW'(1);
					end else begin
						err_d = 1'b1;
					end
				end
				llc_pkg::CMD_CUR_HEAD: begin
					cur_d     = head_q;
					cur_val_d = head_val_q;
				end
				llc_pkg::CMD_DEL_HEAD: begin
					if (is_node(head_q)) begin
						if (cur_q == head_q) begin
							cur_d = NONE;
						end
						head_d     = is_node(link1_s2) ? link1_s2 : NONE;
						head_val_d = value_rdata;
						free_d     = head_q;
						if (count_q != '0) begin
							count_d = count_q - PW'(1);
						end
					end
				end
				llc_pkg::CMD_DEL_AFTER: begin
					if (cur_ok && is_node(link1_s2)) begin
						free_d = link1_s2;
						if (count_q != '0) begin
							count_d = count_q - PW'(1);
						end
					end
				end
				llc_pkg::CMD_INS_AFTER: begin
					if (cur_ok) begin
						if (alloc_ok) begin
							if (is_node(free_q)) begin
								free_d = is_node(link_rdata) ? link_rdata : NONE;
							end else begin
								fresh_d = fresh_q + PW'(1);
							end
							count_d = count_q + PW'(1);
						end else begin
							err_d = 1'b1;
						end
					end
				end
				llc_pkg::CMD_SET_VALUE: begin
					if (cur_ok) begin
						cur_val_d = val_q;
						if (head_q == cur_q) begin
							head_val_d = val_q;
						end
					end
				end
				llc_pkg::CMD_ADVANCE: begin
					if (cur_ok) begin
						cur_d     = is_node(link1_s2) ? link1_s2 : NONE;
						cur_val_d = value_rdata;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= llc_pkg::ST_IDLE;
			done_q  <= 1'b0;
			head_q  <= NONE;
			cur_q   <= NONE;
			free_q  <= NONE;
			fresh_q <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == llc_pkg::ST_COMMIT);
			head_q  <= head_d;
			cur_q   <= cur_d;
			free_q  <= free_d;
			fresh_q <= fresh_d;
			count_q <= count_d;
		end
	end

	// Command beat, first link read and cached values.
	always_ff @(posedge clk) begin
		if (state_q == llc_pkg::ST_IDLE && start) begin
			cmd_q <= llc_pkg::cmd_t'(cmd);
			val_q <= value_in;
		end
		if (state_q == llc_pkg::ST_FETCH) begin
			link1_s2 <= link_rdata;
		end
		head_val_q <= head_val_d;
		cur_val_q  <= cur_val_d;
		err_q      <= err_d;
	end

	// Result beat.
	assign done          = done_q;
	assign head_present  = is_node(head_q);
	assign head_value    = head_present ? head_val_q : '0;
	assign cursor_active = cur_ok;
	assign cursor_value  = cursor_active ? cur_val_q : '0;
	assign element_count = count_q;
	assign pool_error    = err_q;

`ifndef ASSERT_OFF
	// Every accepted command produces its result beat.
	a_result_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result beat missing after accepted command");

	// A result is only shown once the sequencer is back to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a command is in progress");

	// The count never exceeds the pool.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		element_count <= NONE)
		else $error("element count above pool size");

	// The list is empty exactly when the count is zero.
	a_count_head: assert property (@(posedge clk) disable iff (!arst_n)
		(element_count == '0) == !head_present)
		else $error("element count disagrees with head pointer");

	// An active cursor needs a non-empty list.
	a_cursor_list: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_active |-> head_present)
		else $error("cursor active on an empty list");
`endif

endmodule

>>> dv/testbench.sv
// Self-checking testbench for linked_list_with_cursor_top: directed rows, then random beats.
// Depends on llc_pkg and the linked_list_with_cursor_top RTL; carries its own list predictor.
module testbench;

	localparam int POOL = 64;
	localparam int PTR_W = $clog2(POOL + 1);
	localparam int IDX_W = $clog2(POOL);
	localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL);
	localparam int RAND_ITEMS = 1400;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 8;

	// Codes outside the defined set; the block treats them as a query.
	localparam logic [llc_pkg::CMD_W-1:0] CMD_UNKNOWN_LO = 4'd9;
	localparam logic [llc_pkg::CMD_W-1:0] CMD_UNKNOWN_HI = 4'd15;

	localparam logic signed [llc_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [llc_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [llc_pkg::VALUE_W-1:0] VAL_MARK = 32'sh1234_5678;

	typedef struct packed {
		logic signed [llc_pkg::VALUE_W-1:0] head_value;
		logic                               head_present;
		logic signed [llc_pkg::VALUE_W-1:0] cursor_value;
		logic                               cursor_active;
		logic [PTR_W-1:0]                   element_count;
		logic                               pool_error;
	} result_t;

	localparam result_t EMPTY_RES = '{32'sd0, 1'b0, 32'sd0, 1'b0, '0, 1'b0};

	typedef struct {
		logic [llc_pkg::CMD_W-1:0]          op;
		logic signed [llc_pkg::VALUE_W-1:0] val;
		int                                 reps;
		bit                                 fixed;
		result_t                            res;
	} dir_row_t;

	typedef enum {
		MIX_GROW,
		MIX_SHRINK,
		MIX_WALK,
		MIX_NOISE
	} mix_t;

	// Percent of beats preceded by a sender gap, one entry per random segment in turn.
	localparam int IDLE_PHASES [4] = '{0, 71, 0, 20};

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               start = 1'b0;
	logic [llc_pkg::CMD_W-1:0]          cmd = llc_pkg::CMD_QUERY;
	logic signed [llc_pkg::VALUE_W-1:0] value_in = '0;
	logic                               busy;
	logic                               done;
	logic signed [llc_pkg::VALUE_W-1:0] head_value;
	logic                               head_present;
	logic signed [llc_pkg::VALUE_W-1:0] cursor_value;
	logic                               cursor_active;
	logic [PTR_W-1:0]                   element_count;
	logic                               pool_error;

	// Typed expectation that travels with the beat on the command ports.
	bit      fixed_sel = 1'b0;
	result_t fixed_res = EMPTY_RES;

	// Predictor state: node pool, list pointers and element count.
	logic signed [llc_pkg::VALUE_W-1:0] pool_val [POOL];
	logic [PTR_W-1:0]                   pool_link [POOL];
	logic [PTR_W-1:0]                   head_idx;
	logic [PTR_W-1:0]                   cur_idx;
	logic [PTR_W-1:0]                   free_idx;
	logic [PTR_W-1:0]                   fresh_idx;
	logic [PTR_W-1:0]                   held;

	result_t expect_q [$];
	int      idle_pct = 0;
	int      mismatch_cnt = 0;
	int      cmd_cnt = 0;
	int      result_cnt = 0;
	int      refused_cnt = 0;
	int      peak_len = 0;
	int      quiet_cycles = 0;

	// Directed rows: typed results only where the outcome is obvious.
	dir_row_t dir_tab [29] = '{
		'{llc_pkg::CMD_QUERY,      32'sd0,   1,  1'b1, EMPTY_RES},
		'{llc_pkg::CMD_ADVANCE,    32'sd0,   1,  1'b1, EMPTY_RES},
		'{llc_pkg::CMD_SET_VALUE,  VAL_MAX,  1,  1'b1, EMPTY_RES},
		'{llc_pkg::CMD_INS_AFTER,  32'sd1,   1,  1'b1, EMPTY_RES},
		'{llc_pkg::CMD_DEL_AFTER,  32'sd0,   1,  1'b1, EMPTY_RES},
		'{llc_pkg::CMD_DEL_HEAD,   32'sd0,   1,  1'b1, EMPTY_RES},
		'{llc_pkg::CMD_CUR_HEAD,   32'sd0,   1,  1'b1, EMPTY_RES},
		'{llc_pkg::CMD_INS_HEAD,   VAL_MAX,  1,  1'b1,
			'{VAL_MAX, 1'b1, 32'sd0, 1'b0, 7'd1, 1'b0}},
		'{llc_pkg::CMD_CUR_HEAD,   32'sd0,   1,  1'b1,
			'{VAL_MAX, 1'b1, VAL_MAX, 1'b1, 7'd1, 1'b0}},
		'{llc_pkg::CMD_SET_VALUE,  VAL_MIN,  1,  1'b1,
			'{VAL_MIN, 1'b1, VAL_MIN, 1'b1, 7'd1, 1'b0}},
		'{llc_pkg::CMD_DEL_AFTER,  32'sd0,   1,  1'b1,
			'{VAL_MIN, 1'b1, VAL_MIN, 1'b1, 7'd1, 1'b0}},
		'{llc_pkg::CMD_INS_AFTER,  -32'sd1,  1,  1'b0, EMPTY_RES},
		'{llc_pkg::CMD_INS_HEAD,   32'sd0,   1,  1'b0, EMPTY_RES},
		'{llc_pkg::CMD_ADVANCE,    32'sd0,   1,  1'b0, EMPTY_RES},
		'{llc_pkg::CMD_ADVANCE,    32'sd0,   1,  1'b0, EMPTY_RES},
		'{llc_pkg::CMD_ADVANCE,    32'sd0,   1,  1'b0, EMPTY_RES},
		'{llc_pkg::CMD_CUR_HEAD,   32'sd0,   1,  1'b0, EMPTY_RES},
		'{llc_pkg::CMD_DEL_HEAD,   32'sd0,   1,  1'b0, EMPTY_RES},
		'{CMD_UNKNOWN_LO,          VAL_MARK, 1,  1'b0, EMPTY_RES},
		'{CMD_UNKNOWN_HI,          VAL_MIN,  1,  1'b0, EMPTY_RES},
		'{llc_pkg::CMD_CLEAR,      32'sd0,   1,  1'b1, EMPTY_RES},
		'{llc_pkg::CMD_INS_HEAD,   32'sd0,   63, 1'b0, EMPTY_RES},
		'{llc_pkg::CMD_INS_HEAD,   VAL_MARK, 1,  1'b1,
			'{VAL_MARK, 1'b1, 32'sd0, 1'b0, 7'd64, 1'b0}},
		'{llc_pkg::CMD_INS_HEAD,   32'sd5,   1,  1'b1,
			'{VAL_MARK, 1'b1, 32'sd0, 1'b0, 7'd64, 1'b1}},
		'{llc_pkg::CMD_CUR_HEAD,   32'sd0,   1,  1'b1,
			'{VAL_MARK, 1'b1, VAL_MARK, 1'b1, 7'd64, 1'b0}},
		'{llc_pkg::CMD_INS_AFTER,  32'sd7,   1,  1'b1,
			'{VAL_MARK, 1'b1, VAL_MARK, 1'b1, 7'd64, 1'b1}},
		'{llc_pkg::CMD_DEL_AFTER,  32'sd0,   1,  1'b0, EMPTY_RES},
		'{llc_pkg::CMD_INS_AFTER,  -32'sd2,  1,  1'b0, EMPTY_RES},
		'{llc_pkg::CMD_CLEAR,      32'sd0,   1,  1'b1, EMPTY_RES}
	};

	linked_list_with_cursor_top #(
		.POOL_NODES(POOL)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.value_in(value_in),
		.done(done),
		.head_value(head_value),
		.head_present(head_present),
		.cursor_value(cursor_value),
		.cursor_active(cursor_active),
		.element_count(element_count),
		.pool_error(pool_error)
	);

	always #4 clk = ~clk;

	// Pool entry that a pointer names.
	function automatic logic [IDX_W-1:0] slot(input logic [PTR_W-1:0] p);
		return p[IDX_W-1:0];
	endfunction

	// Empty list, no cursor, whole pool free.
	function automatic void empty_list();
		head_idx = NIL;
		cur_idx = NIL;
		free_idx = NIL;
		fresh_idx = '0;
		held = '0;
	endfunction

	// Free chain first, then the next never-used node; NIL when the pool is full.
	function automatic logic [PTR_W-1:0] grab_node();
		logic [PTR_W-1:0] n;
		n = NIL;
		if (free_idx != NIL) begin
			n = free_idx;
			free_idx = pool_link[slot(n)];
		end else if (fresh_idx < POOL) begin
			n = fresh_idx;
			fresh_idx = fresh_idx + 1'b1;
		end
		return n;
	endfunction

	function automatic void drop_node(input logic [PTR_W-1:0] n);
		pool_link[slot(n)] = free_idx;
		free_idx = n;
		if (held != 0) begin
			held = held - 1'b1;
		end
	endfunction

	// Applies one command to the predicted list and returns the result it should report.
	function automatic result_t apply_list_cmd(input logic [llc_pkg::CMD_W-1:0] op,
			input logic signed [llc_pkg::VALUE_W-1:0] v);
		result_t          r;
		logic             refused;
		logic [PTR_W-1:0] n;
		logic [PTR_W-1:0] d;
		refused = 1'b0;
		case (op)
			llc_pkg::CMD_CLEAR: begin
				empty_list();
			end
			llc_pkg::CMD_INS_HEAD: begin
				n = grab_node();
				if (n == NIL) begin
					refused = 1'b1;
				end else begin
					pool_val[slot(n)] = v;
					pool_link[slot(n)] = head_idx;
					head_idx = n;
					held = held + 1'b1;
				end
			end
			llc_pkg::CMD_CUR_HEAD: begin
				cur_idx = head_idx;
			end
			llc_pkg::CMD_DEL_HEAD: begin
				if (head_idx != NIL) begin
					n = head_idx;
					if (cur_idx == n) begin
						cur_idx = NIL;
					end
					head_idx = pool_link[slot(n)];
					drop_node(n);
				end
			end
			llc_pkg::CMD_DEL_AFTER: begin
				if (cur_idx != NIL && pool_link[slot(cur_idx)] != NIL) begin
					d = pool_link[slot(cur_idx)];
					pool_link[slot(cur_idx)] = pool_link[slot(d)];
					drop_node(d);
				end
			end
			llc_pkg::CMD_INS_AFTER: begin
				if (cur_idx != NIL) begin
					n = grab_node();
					if (n == NIL) begin
						refused = 1'b1;
					end else begin
						pool_val[slot(n)] = v;
						pool_link[slot(n)] = pool_link[slot(cur_idx)];
						pool_link[slot(cur_idx)] = n;
						held = held + 1'b1;
					end
				end
			end
			llc_pkg::CMD_SET_VALUE: begin
				if (cur_idx != NIL) begin
					pool_val[slot(cur_idx)] = v;
				end
			end
			llc_pkg::CMD_ADVANCE: begin
				if (cur_idx != NIL) begin
					cur_idx = pool_link[slot(cur_idx)];
				end
			end
			default: begin
			end
		endcase
		r.head_present = (head_idx != NIL);
		r.head_value = r.head_present ? pool_val[slot(head_idx)] : '0;
		r.cursor_active = (cur_idx != NIL);
		r.cursor_value = r.cursor_active ? pool_val[slot(cur_idx)] : '0;
		r.element_count = held;
		r.pool_error = refused;
		return r;
	endfunction

	// Presents one command beat, after an optional sender gap, and returns once it is taken.
	task automatic send_cmd(input logic [llc_pkg::CMD_W-1:0] op,
			input logic signed [llc_pkg::VALUE_W-1:0] v,
			input bit fixed, input result_t res);
		int gap;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		value_in <= v;
		fixed_sel <= fixed;
		fixed_res <= res;
		do @(posedge clk); while (busy);
	endtask

	// Command mix for one random segment.
	function automatic logic [llc_pkg::CMD_W-1:0] pick_cmd(input mix_t mix);
		int r;
		r = $urandom_range(99);
		case (mix)
			MIX_GROW: begin
				if (r < 45) return llc_pkg::CMD_INS_HEAD;
				if (r < 65) return llc_pkg::CMD_INS_AFTER;
				if (r < 75) return llc_pkg::CMD_CUR_HEAD;
				if (r < 90) return llc_pkg::CMD_ADVANCE;
				if (r < 95) return llc_pkg::CMD_SET_VALUE;
				return llc_pkg::CMD_QUERY;
			end
			MIX_SHRINK: begin
				if (r < 35) return llc_pkg::CMD_DEL_HEAD;
				if (r < 60) return llc_pkg::CMD_DEL_AFTER;
				if (r < 70) return llc_pkg::CMD_CUR_HEAD;
				if (r < 85) return llc_pkg::CMD_ADVANCE;
				if (r < 95) return llc_pkg::CMD_INS_HEAD;
				return llc_pkg::CMD_QUERY;
			end
			MIX_WALK: begin
				if (r < 35) return llc_pkg::CMD_ADVANCE;
				if (r < 55) return llc_pkg::CMD_SET_VALUE;
				if (r < 70) return llc_pkg::CMD_CUR_HEAD;
				if (r < 80) return llc_pkg::CMD_INS_AFTER;
				if (r < 90) return llc_pkg::CMD_DEL_AFTER;
				if (r < 95) return llc_pkg::CMD_INS_HEAD;
				return llc_pkg::CMD_DEL_HEAD;
			end
			default: begin
				return llc_pkg::CMD_W'($urandom_range(15));
			end
		endcase
	endfunction

	// Mostly full-range values, with the corner values now and then.
	function automatic logic signed [llc_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(15))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Field-by-field comparison of one result beat.
	function automatic void check_result(input result_t got, input result_t want);
		if (got.head_value !== want.head_value) begin
			$error("head_value: expected %0d actual %0d", want.head_value, got.head_value);
			mismatch_cnt++;
		end
		if (got.head_present !== want.head_present) begin
			$error("head_present: expected %0d actual %0d", want.head_present, got.head_present);
			mismatch_cnt++;
		end
		if (got.cursor_value !== want.cursor_value) begin
			$error("cursor_value: expected %0d actual %0d", want.cursor_value, got.cursor_value);
			mismatch_cnt++;
		end
		if (got.cursor_active !== want.cursor_active) begin
			$error("cursor_active: expected %0d actual %0d", want.cursor_active,
				got.cursor_active);
			mismatch_cnt++;
		end
		if (got.element_count !== want.element_count) begin
			$error("element_count: expected %0d actual %0d", want.element_count,
				got.element_count);
			mismatch_cnt++;
		end
		if (got.pool_error !== want.pool_error) begin
			$error("pool_error: expected %0d actual %0d", want.pool_error, got.pool_error);
			mismatch_cnt++;
		end
	endfunction

	// Result beats are checked against the oldest expectation; accepted commands queue a new one.
	always @(posedge clk) begin : monitor
		result_t got;
		result_t pred;
		if (arst_n) begin
			if (done) begin
				got = '{head_value, head_present, cursor_value, cursor_active, element_count,
					pool_error};
				result_cnt++;
				if (got.pool_error === 1'b1) begin
					refused_cnt++;
				end
				if (int'(got.element_count) > peak_len) begin
					peak_len = int'(got.element_count);
				end
				if (expect_q.size() == 0) begin
					$error("result beat with no command outstanding");
					mismatch_cnt++;
				end else begin
					check_result(got, expect_q.pop_front());
				end
			end
			if (start && !busy) begin
				pred = apply_list_cmd(cmd, value_in);
				cmd_cnt++;
				expect_q.push_back(fixed_sel ? fixed_res : pred);
			end
		end
	end

	// Ends the run when nothing moves for too long.
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$error("no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Reset, directed rows, random segments, then drain.
	initial begin : stimulus
		int   seg;
		int   seg_len;
		int   rand_sent;
		mix_t mix;
		logic signed [llc_pkg::VALUE_W-1:0] v;
		seg = 0;
		rand_sent = 0;
		empty_list();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		idle_pct = 0;
		foreach (dir_tab[i]) begin
			for (int k = 0; k < dir_tab[i].reps; k++) begin
				v = (dir_tab[i].reps > 1) ? pick_value() : dir_tab[i].val;
				send_cmd(dir_tab[i].op, v, dir_tab[i].fixed, dir_tab[i].res);
			end
		end

		// Segments lean toward growth so that the pool fills up now and then.
		while (rand_sent < RAND_ITEMS) begin
			case ($urandom_range(9))
				0, 1, 2, 3: mix = MIX_GROW;
				4, 5: mix = MIX_SHRINK;
				6, 7, 8: mix = MIX_WALK;
				default: mix = MIX_NOISE;
			endcase
			seg_len = (mix == MIX_NOISE) ? $urandom_range(10, 30) : $urandom_range(40, 120);
			idle_pct = IDLE_PHASES[seg % 4];
			repeat (seg_len) begin
				send_cmd(pick_cmd(mix), pick_value(), 1'b0, EMPTY_RES);
				rand_sent++;
			end
			seg++;
		end

		start <= 1'b0;
		while (expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d commands over %0d random segments, %0d results checked",
			cmd_cnt, seg, result_cnt);
		$display("summary: %0d inserts refused on a full pool, longest list %0d elements",
			refused_cnt, peak_len);
		if (mismatch_cnt == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/llc_pkg.sv
rtl/llc_node_mem.sv
rtl/linked_list_with_cursor_top.sv
dv/testbench.sv
